// ===== src/assert_macros.svh =====
// Assertion macros shared by the transcoder RTL.
// Each macro expands to one labeled concurrent assertion on a clock with active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in every cycle outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds, post must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/tuf_pkg.sv =====
// Shared types and constants of the UTF-16LE to UTF-8 transcoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tuf_pkg;

    localparam int unsigned JOB_BYTES = 8;

    localparam logic [5:0]  HIGH_TAG        = 6'b110110;
    localparam logic [5:0]  LOW_TAG         = 6'b110111;
    localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;
    localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;

    localparam logic [7:0]  REPL_B0   = 8'hEF;
    localparam logic [7:0]  REPL_B1   = 8'hBF;
    localparam logic [7:0]  REPL_B2   = 8'hBD;
    localparam logic [7:0]  TERM_BYTE = 8'h00;

    // Bytes of one input unit, emitted in order from index 0.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                n;
        logic                      fin;
    } t_job;

endpackage

`default_nettype wire

// ===== src/tuf_ifs.sv =====
// Handshake channel interfaces of the transcoder: code units in, bytes out, config write.
// Depends on nothing; valid and ready move one transaction per edge when both are high.
`default_nettype none

interface tuf_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        final_unit;
    modport source (output valid, code_unit, final_unit, input ready);
    modport sink   (input valid, code_unit, final_unit, output ready);
endinterface

interface tuf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
    modport source (output valid, out_byte, run_end, string_end, input ready);
    modport sink   (input valid, out_byte, run_end, string_end, output ready);
endinterface

interface tuf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_units;
    modport source (output valid, max_units, input ready);
    modport sink   (input valid, max_units, output ready);
endinterface

`default_nettype wire

// ===== src/utf16le_to_utf8_transcoder_unit.sv =====
// UTF-16LE to UTF-8 transcoder: accepts one code unit per transaction on i_unit and delivers
// UTF-8 bytes one per transaction on o_byte. A unit is accepted whenever the two-entry job queue
// has room, so units enter back to back while bytes drain; each unit then causes as many output
// bytes as its job holds (0 for a held high surrogate, 1 to 3 for a BMP unit, 4 for a pair,
// up to 7 when a flush and a terminator are added). The sustained rate is set by the byte-wide
// output port. max_units must be written through i_cfg only while the block is idle; the block
// itself does not enforce this. max_units resets to 65535.
// Depends on tuf_pkg, tuf_ifs.sv, tuf_front, tuf_queue and tuf_back.
`default_nettype none

module utf16le_to_utf8_transcoder_unit
    import tuf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    tuf_unit_if.sink    i_unit,
    tuf_cfg_if.sink     i_cfg,
    tuf_byte_if.source  o_byte
);

    logic push, pop, full, empty;
    t_job job, head;

    tuf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_unit  (i_unit),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    tuf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    tuf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

`default_nettype wire

// ===== src/tuf_front.sv =====
// Front end: accepts code units, tracks surrogate and count state, builds byte jobs.
// Depends on tuf_pkg and the channel interfaces in tuf_ifs.sv.
`default_nettype none
`include "assert_macros.svh"

module tuf_front
    import tuf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    tuf_unit_if.sink    i_unit,
    tuf_cfg_if.sink     i_cfg,
    input  wire         i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [15:0] r_max_units;
    logic [9:0]  r_held_high;
    logic        r_held_valid;
    logic [15:0] r_count;

    logic [15:0] c;
    logic        accept;
    logic        is_zero, is_high, is_low;
    logic [15:0] count_inc;
    logic        fin, pair, a_repl, new_held;
    logic [20:0] cp;
    t_job        job;

    assign i_cfg.ready  = 1'b1;
    assign i_unit.ready = !i_full;
    assign accept       = i_unit.valid && !i_full;

    assign c         = i_unit.code_unit;
    assign is_zero   = (c == 16'd0);
    assign is_high   = (c[15:10] == HIGH_TAG);
    assign is_low    = (c[15:10] == LOW_TAG);
    assign count_inc = r_count + 16'd1;
    assign fin       = is_zero || i_unit.final_unit || (count_inc >= r_max_units);
    assign pair      = !is_zero && r_held_valid && is_low;
    assign a_repl    = r_held_valid && !pair;
    assign new_held  = !is_zero && is_high;
    assign cp        = SUPP_BASE + {1'b0, r_held_high, c[9:0]};

    always_comb begin
        logic [2:0] pos;
        pos = 3'd0;
        job = '0;
        // held unit that did not pair flushes first
        if (a_repl) begin
            job.bytes[pos] = REPL_B0; pos = pos + 3'd1;
            job.bytes[pos] = REPL_B1; pos = pos + 3'd1;
            job.bytes[pos] = REPL_B2; pos = pos + 3'd1;
        end
        if (!is_zero) begin
            priority if (pair) begin
                job.bytes[pos] = {5'b11110, cp[20:18]}; pos = pos + 3'd1;
                job.bytes[pos] = {2'b10, cp[17:12]};    pos = pos + 3'd1;
                job.bytes[pos] = {2'b10, cp[11:6]};     pos = pos + 3'd1;
                job.bytes[pos] = {2'b10, cp[5:0]};      pos = pos + 3'd1;
            end else if (is_high) begin
                pos = pos;
            end else if (is_low) begin
                job.bytes[pos] = REPL_B0; pos = pos + 3'd1;
                job.bytes[pos] = REPL_B1; pos = pos + 3'd1;
                job.bytes[pos] = REPL_B2; pos = pos + 3'd1;
            end else if (c < ONE_BYTE_LIMIT) begin
                job.bytes[pos] = {1'b0, c[6:0]}; pos = pos + 3'd1;
            end else if (c < TWO_BYTE_LIMIT) begin
                job.bytes[pos] = {3'b110, c[10:6]}; pos = pos + 3'd1;
                job.bytes[pos] = {2'b10, c[5:0]};   pos = pos + 3'd1;
            end else begin
                job.bytes[pos] = {4'b1110, c[15:12]}; pos = pos + 3'd1;
                job.bytes[pos] = {2'b10, c[11:6]};    pos = pos + 3'd1;
                job.bytes[pos] = {2'b10, c[5:0]};     pos = pos + 3'd1;
            end
        end
        if (fin) begin
            // a high surrogate that arrives at string end flushes at once
            if (new_held) begin
                job.bytes[pos] = REPL_B0; pos = pos + 3'd1;
                job.bytes[pos] = REPL_B1; pos = pos + 3'd1;
                job.bytes[pos] = REPL_B2; pos = pos + 3'd1;
            end
            job.bytes[pos] = TERM_BYTE; pos = pos + 3'd1;
        end
        job.n   = pos;
        job.fin = fin;
    end

    assign o_job  = job;
    assign o_push = accept && (job.n != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= MAX_UNITS_RESET;
        end else if (i_cfg.valid) begin
            r_max_units <= i_cfg.max_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_high  <= 10'd0;
            r_count      <= 16'd0;
        end else if (accept) begin
            if (fin) begin
                r_held_valid <= 1'b0;
                r_held_high  <= 10'd0;
                r_count      <= 16'd0;
            end else begin
                r_held_valid <= new_held;
                r_held_high  <= new_held ? c[9:0] : 10'd0;
                r_count      <= count_inc;
            end
        end
    end

    `ASSERT_NEXT(a_fin_clears_state, i_clk, i_rst_n, accept && fin,
        !r_held_valid && (r_count == 16'd0), "string end left state behind")
    `ASSERT_ALWAYS(a_no_empty_push, i_clk, i_rst_n,
        !o_push || (o_job.n != 3'd0), "empty job pushed")

endmodule

`default_nettype wire

// ===== src/tuf_queue.sv =====
// Two-entry job queue between the front end and the byte serializer.
// Depends on tuf_pkg for the job type.
`default_nettype none
`include "assert_macros.svh"

module tuf_queue
    import tuf_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_job,
    input  wire   i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_job  o_head
);

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n,
        !(i_push && o_full) && !(i_pop && o_empty), "queue over or underflow")

endmodule

`default_nettype wire

// ===== src/tuf_back.sv =====
// Back end: serializes the head job of the queue one byte per output transaction.
// Depends on tuf_pkg and the byte channel interface in tuf_ifs.sv.
`default_nettype none
`include "assert_macros.svh"

module tuf_back
    import tuf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    tuf_byte_if.source  o_byte
);

    logic [2:0] r_idx;
    logic       last_byte;
    logic       take;

    assign last_byte         = (r_idx == (i_head.n - 3'd1));
    assign take              = o_byte.valid && o_byte.ready;
    assign o_byte.valid      = !i_empty;
    assign o_byte.out_byte   = i_head.bytes[r_idx];
    assign o_byte.run_end    = last_byte;
    assign o_byte.string_end = last_byte && i_head.fin;
    assign o_pop             = take && last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (take) begin
            r_idx <= last_byte ? 3'd0 : r_idx + 3'd1;
        end
    end

    `ASSERT_ALWAYS(a_idx_in_job, i_clk, i_rst_n,
        i_empty || (r_idx < i_head.n), "byte index past end of job")

endmodule

`default_nettype wire
